@@ rtl/rsp_pkg.sv @@
// Shared types and constants for the ramped speed to PWM block.
// Holds the item and result structs, the configuration struct and register indexes.
// Depends on nothing; used by rsp_pulse and ramped_speed_to_pwm.
`default_nettype none

package rsp_pkg;

    localparam int COUNT_BITS = 25;

    localparam logic [7:0] SPEED_STOP = 8'd127;
    localparam logic [7:0] GOAL_LOW   = 8'd27;
    localparam logic [7:0] GOAL_HIGH  = 8'd227;
    localparam int         SPEED_LIMIT = 100;

    // Divide by 100 as multiply by reciprocal, then one correction step.
    localparam int RECIP_SHIFT = COUNT_BITS + 7;
    localparam logic [COUNT_BITS:0] RECIP_MUL =
        (COUNT_BITS + 1)'((64'd1 << RECIP_SHIFT) / 64'd100);

    localparam logic [7:0]            RESET_RAMP_STEP = 8'd10;
    localparam logic [COUNT_BITS-1:0] RESET_PERIOD    = COUNT_BITS'(20000000);
    localparam logic [COUNT_BITS-1:0] RESET_PULSE_MIN = COUNT_BITS'(1000000);
    localparam logic [COUNT_BITS-1:0] RESET_PULSE_MAX = COUNT_BITS'(2000000);

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_OUTPUT_MODE     = 3'd0,
        CFG_RAMP_STEP       = 3'd1,
        CFG_PWM_PERIOD      = 3'd2,
        CFG_SERVO_PULSE_MIN = 3'd3,
        CFG_SERVO_PULSE_MAX = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        ACTION_SET  = 1'b0,
        ACTION_TICK = 1'b1
    } t_action;

    typedef enum logic {
        MODE_BRIDGE = 1'b0,
        MODE_SERVO  = 1'b1
    } t_mode;

    typedef struct packed {
        logic       action;
        logic [7:0] target_speed;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0] pulse_a;
        logic [COUNT_BITS-1:0] pulse_b;
        logic [7:0]            current_speed;
    } t_out_item;

    typedef struct packed {
        logic                  output_mode;
        logic [7:0]            ramp_step;
        logic [COUNT_BITS-1:0] pwm_period;
        logic [COUNT_BITS-1:0] servo_pulse_min;
        logic [COUNT_BITS-1:0] servo_pulse_max;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/rsp_pulse.sv @@
// Pulse width pipeline: turns a new speed byte into bridge or servo pulse widths.
// Four register stages plus the output register, each stage holds while the next is full.
// Depends on rsp_pkg for widths, constants and the config and result structs.
`default_nettype none

module rsp_pulse (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_speed,
    input  wire rsp_pkg::t_cfg    i_cfg,
    output logic                  o_stall,
    output logic                  o_out_valid,
    output rsp_pkg::t_out_item    o_out,
    input  wire logic             i_out_stall
);

    localparam int CW = rsp_pkg::COUNT_BITS;
    localparam int QW = CW - 6;
    localparam int PW = 2 * CW + 1;

    // stage enables
    logic en_out, en_s4, en_s3, en_s2, en_s1;

    // stage 1 registers
    logic       r_s1_valid;
    logic [7:0] r_s1_speed;

    // stage 1 logic
    logic signed [8:0]  s1_diff;
    logic signed [7:0]  s1_s;
    logic [CW-1:0]      s1_pm1;
    logic signed [CW:0] s1_rng;
    logic [CW-1:0]      s1_rabs;
    logic [PW-1:0]      s1_prod_b;
    logic [PW-1:0]      s1_prod_r;

    // stage 2 registers
    logic               r_s2_valid;
    logic [7:0]         r_s2_speed;
    logic signed [7:0]  r_s2_s;
    logic [QW-1:0]      r_s2_q0_b;
    logic [QW-1:0]      r_s2_q0_r;
    logic [CW-1:0]      r_s2_pm1;
    logic [CW-1:0]      r_s2_rabs;
    logic signed [CW:0] r_s2_rng;

    // stage 2 logic
    logic [CW-1:0]        s2_rem_b;
    logic [CW-1:0]        s2_rem_r;
    logic [QW-1:0]        s2_per;
    logic [QW-1:0]        s2_q_r;
    logic signed [QW:0]   s2_rq;
    logic signed [CW:0]   s2_half;
    logic signed [CW+1:0] s2_mid;
    logic [6:0]           s2_mag;

    // stage 3 registers
    logic                 r_s3_valid;
    logic [7:0]           r_s3_speed;
    logic signed [7:0]    r_s3_s;
    logic [6:0]           r_s3_mag;
    logic [QW-1:0]        r_s3_per;
    logic signed [QW:0]   r_s3_rq;
    logic signed [CW+1:0] r_s3_mid;

    // stage 3 logic
    logic [CW:0]          s3_pb;
    logic signed [CW+2:0] s3_ps;

    // stage 4 registers
    logic                 r_s4_valid;
    logic [7:0]           r_s4_speed;
    logic signed [7:0]    r_s4_s;
    logic [CW:0]          r_s4_pb;
    logic signed [CW+2:0] r_s4_ps;
    logic signed [CW+1:0] r_s4_mid;

    // stage 4 logic
    logic [CW-1:0]        s4_pc;
    logic signed [CW+3:0] s4_sum;
    logic [CW-1:0]        s4_servo;
    rsp_pkg::t_out_item   n_out;

    // output register
    logic               r_out_valid;
    rsp_pkg::t_out_item r_out;

    assign en_out  = !r_out_valid || !i_out_stall;
    assign en_s4   = !r_s4_valid || en_out;
    assign en_s3   = !r_s3_valid || en_s4;
    assign en_s2   = !r_s2_valid || en_s3;
    assign en_s1   = !r_s1_valid || en_s2;
    assign o_stall = !en_s1;

    // ---------------- stage 1: signed speed, reciprocal products
    always_comb begin
        s1_diff = $signed({1'b0, r_s1_speed}) - $signed({1'b0, rsp_pkg::SPEED_STOP});
        if (s1_diff > 9'sd100) begin
            s1_s = 8'sd100;
        end else if (s1_diff < -9'sd100) begin
            s1_s = -8'sd100;
        end else begin
            s1_s = s1_diff[7:0];
        end

        s1_pm1 = (i_cfg.pwm_period == '0) ? '0 : i_cfg.pwm_period - CW'(1);
        s1_rng = $signed({1'b0, i_cfg.servo_pulse_max})
               - $signed({1'b0, i_cfg.servo_pulse_min});
        s1_rabs = s1_rng[CW] ? CW'(-s1_rng) : CW'(s1_rng);

        s1_prod_b = PW'(s1_pm1) * PW'(rsp_pkg::RECIP_MUL);
        s1_prod_r = PW'(s1_rabs) * PW'(rsp_pkg::RECIP_MUL);
    end

    // ---------------- stage 2: quotient correction, servo midpoint
    always_comb begin
        s2_rem_b = r_s2_pm1 - CW'(r_s2_q0_b) * CW'(rsp_pkg::SPEED_LIMIT);
        s2_rem_r = r_s2_rabs - CW'(r_s2_q0_r) * CW'(rsp_pkg::SPEED_LIMIT);
        s2_per   = r_s2_q0_b + QW'(s2_rem_b >= CW'(rsp_pkg::SPEED_LIMIT));
        s2_q_r   = r_s2_q0_r + QW'(s2_rem_r >= CW'(rsp_pkg::SPEED_LIMIT));
        // quotient of a negative range truncates toward zero
        s2_rq    = r_s2_rng[CW] ? -$signed({1'b0, s2_q_r}) : $signed({1'b0, s2_q_r});
        s2_half  = (r_s2_rng + $signed({{CW{1'b0}}, r_s2_rng[CW]})) >>> 1;
        s2_mid   = $signed({2'b00, i_cfg.servo_pulse_min}) + {s2_half[CW], s2_half};
        s2_mag   = r_s2_s[7] ? 7'(-r_s2_s) : 7'(r_s2_s);
    end

    // ---------------- stage 3: the two products
    always_comb begin
        s3_pb = (CW + 1)'(r_s3_mag) * (CW + 1)'(r_s3_per);
        s3_ps = $signed({{(CW - 5){r_s3_s[7]}}, r_s3_s})
              * $signed({{(CW + 2 - QW){r_s3_rq[QW]}}, r_s3_rq});
    end

    // ---------------- stage 4: clamp and select
    always_comb begin
        s4_pc = (r_s4_pb > {1'b0, i_cfg.pwm_period}) ? i_cfg.pwm_period : r_s4_pb[CW-1:0];

        s4_sum = {{2{r_s4_mid[CW+1]}}, r_s4_mid} + {r_s4_ps[CW+2], r_s4_ps};
        if (s4_sum[CW+3]) begin
            s4_servo = '0;
        end else if (s4_sum > $signed({4'b0000, i_cfg.pwm_period})) begin
            s4_servo = i_cfg.pwm_period;
        end else begin
            s4_servo = s4_sum[CW-1:0];
        end

        n_out.current_speed = r_s4_speed;
        if (i_cfg.output_mode == rsp_pkg::MODE_SERVO) begin
            n_out.pulse_a = s4_servo;
            n_out.pulse_b = '0;
        end else begin
            n_out.pulse_a = (r_s4_s > 8'sd0) ? s4_pc : '0;
            n_out.pulse_b = (r_s4_s < 8'sd0) ? s4_pc : '0;
        end
    end

    // ---------------- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1) begin
                r_s1_valid <= i_valid;
            end
            if (en_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en_s3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (en_s4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    // ---------------- payload registers
    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_speed <= i_speed;
        end
        if (en_s2) begin
            r_s2_speed <= r_s1_speed;
            r_s2_s     <= s1_s;
            r_s2_q0_b  <= s1_prod_b[rsp_pkg::RECIP_SHIFT +: QW];
            r_s2_q0_r  <= s1_prod_r[rsp_pkg::RECIP_SHIFT +: QW];
            r_s2_pm1   <= s1_pm1;
            r_s2_rabs  <= s1_rabs;
            r_s2_rng   <= s1_rng;
        end
        if (en_s3) begin
            r_s3_speed <= r_s2_speed;
            r_s3_s     <= r_s2_s;
            r_s3_mag   <= s2_mag;
            r_s3_per   <= s2_per;
            r_s3_rq    <= s2_rq;
            r_s3_mid   <= s2_mid;
        end
        if (en_s4) begin
            r_s4_speed <= r_s3_speed;
            r_s4_s     <= r_s3_s;
            r_s4_pb    <= s3_pb;
            r_s4_ps    <= s3_ps;
            r_s4_mid   <= r_s3_mid;
        end
        if (en_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ rtl/ramped_speed_to_pwm.sv @@
// Ramped speed to PWM: one item per clock in, and a result for each accepted tick that
// moves the speed, as long as the output side takes results. The speed state
// updates in the accept cycle, so ticks may follow each other back to back; the
// latency comes from the pulse pipeline (reciprocal divide, correction, multiply,
// clamp, output register). Set commands and ticks that do not move give no result.
// Configuration writes are taken every cycle and should be made while the block is idle.
`default_nettype none

module ramped_speed_to_pwm (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire rsp_pkg::t_in_item                     i_in,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output rsp_pkg::t_out_item                         o_out,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [rsp_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [rsp_pkg::COUNT_BITS-1:0]        i_cfg_data
);

    rsp_pkg::t_cfg r_cfg;
    logic [7:0]    r_speed_now;
    logic [7:0]    r_speed_goal;
    logic [7:0]    n_speed_now;
    logic [7:0]    n_speed_goal;

    logic              in_accept;
    logic              emit;
    logic              pulse_stall;
    logic signed [9:0] diff;
    logic signed [9:0] step;
    logic signed [9:0] move;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = pulse_stall;
    assign in_accept   = i_in_valid && !pulse_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_mode     <= rsp_pkg::MODE_BRIDGE;
            r_cfg.ramp_step       <= rsp_pkg::RESET_RAMP_STEP;
            r_cfg.pwm_period      <= rsp_pkg::RESET_PERIOD;
            r_cfg.servo_pulse_min <= rsp_pkg::RESET_PULSE_MIN;
            r_cfg.servo_pulse_max <= rsp_pkg::RESET_PULSE_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (rsp_pkg::t_cfg_idx'(i_cfg_index))
                rsp_pkg::CFG_OUTPUT_MODE:     r_cfg.output_mode     <= i_cfg_data[0];
                rsp_pkg::CFG_RAMP_STEP:       r_cfg.ramp_step       <= i_cfg_data[7:0];
                rsp_pkg::CFG_PWM_PERIOD:      r_cfg.pwm_period      <= i_cfg_data;
                rsp_pkg::CFG_SERVO_PULSE_MIN: r_cfg.servo_pulse_min <= i_cfg_data;
                rsp_pkg::CFG_SERVO_PULSE_MAX: r_cfg.servo_pulse_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // target and ramp step
    always_comb begin
        n_speed_goal = r_speed_goal;
        if (in_accept && i_in.action == rsp_pkg::ACTION_SET) begin
            if (i_in.target_speed < rsp_pkg::GOAL_LOW) begin
                n_speed_goal = rsp_pkg::GOAL_LOW;
            end else if (i_in.target_speed > rsp_pkg::GOAL_HIGH) begin
                n_speed_goal = rsp_pkg::GOAL_HIGH;
            end else begin
                n_speed_goal = i_in.target_speed;
            end
        end

        diff = $signed({2'b00, r_speed_goal}) - $signed({2'b00, r_speed_now});
        step = $signed({2'b00, r_cfg.ramp_step});
        if (diff > step) begin
            move = step;
        end else if (diff < -step) begin
            move = -step;
        end else begin
            move = diff;
        end

        emit = in_accept && (i_in.action == rsp_pkg::ACTION_TICK)
            && (r_speed_now != r_speed_goal) && (r_cfg.ramp_step != 8'd0);

        n_speed_now = emit ? r_speed_now + move[7:0] : r_speed_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_now  <= rsp_pkg::SPEED_STOP;
            r_speed_goal <= rsp_pkg::SPEED_STOP;
        end else begin
            r_speed_now  <= n_speed_now;
            r_speed_goal <= n_speed_goal;
        end
    end

    rsp_pulse u_pulse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (emit),
        .i_speed     (n_speed_now),
        .i_cfg       (r_cfg),
        .o_stall     (pulse_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTHESIS
    a_speed_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_speed_now >= rsp_pkg::GOAL_LOW) && (r_speed_now <= rsp_pkg::GOAL_HIGH))
        else $error("current speed left the goal range");

    a_speed_moves_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_speed_now != $past(r_speed_now))
            |-> $past(in_accept && (i_in.action == rsp_pkg::ACTION_TICK)))
        else $error("current speed changed without an accepted tick");

    a_one_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.pulse_a == '0) || (o_out.pulse_b == '0)))
        else $error("both pulse channels driven at once");
`endif

endmodule

`default_nettype wire
